// File: design/rf_phase_calibration_unit_macros.svh
// Assertion macros for the phase calibration unit.
// Expects clk_i and rst_ni in the scope of the user; no other dependencies.
`ifndef RF_PHASE_CALIBRATION_UNIT_MACROS_SVH
`define RF_PHASE_CALIBRATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rpc_pkg.sv
// Shared constants, types and helper functions of the phase calibration unit.
// No dependencies.
package rpc_pkg;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int COEFF_FRAC_BITS = 40;
  localparam int DATA_W          = 64;
  localparam int GOLD_W          = 26;
  localparam int NUM_COEFF       = 6;
  localparam int CFG_IDX_W       = 3;

  // 360 degrees = 45 * 8, raw scale is 45 / 4096 degrees per count
  localparam int RAW_SCALE   = 45;
  localparam int MOD_BASE    = 45;
  localparam int MOD_RECIP   = 23302;  // ceil(2^20 / 45)
  localparam int MOD_SHIFT   = 20;
  localparam int CHUNK_W     = 12;     // 2^12 = 1 mod 45
  localparam int CHUNK_SUM_W = 15;

  localparam int STEP_LAT   = 3;
  localparam int POLY_STEPS = 5;
  localparam int POLY_LAT   = STEP_LAT * POLY_STEPS;
  localparam int FRONT_LAT  = 3;
  localparam int WRAP_LAT   = 4;
  localparam int PIPE_LAT   = FRONT_LAT + POLY_LAT + 2 + WRAP_LAT;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GOLD_OFFSET,
    REG_COEFF_0,
    REG_COEFF_1,
    REG_COEFF_2,
    REG_COEFF_3,
    REG_COEFF_4,
    REG_COEFF_5
  } cfg_reg_e;

  typedef logic [NUM_COEFF-1:0][DATA_W-1:0] coeff_set_t;

  // 2^n mod 45, evaluated at elaboration
  function automatic int pow2_mod(input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) begin
      r = (r * 2) % MOD_BASE;
    end
    return r;
  endfunction

endpackage

// File: design/rpc_step.sv
// One Horner step f*x + c in three stages: partial products, rounding sum,
// saturate and add. Depends on rpc_pkg.
module rpc_step #(
  parameter int PHASE_FRAC_BITS = rpc_pkg::PHASE_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [63:0]              f_i,
  input  logic signed [PHASE_FRAC_BITS+9:0] x_i,
  input  logic signed [63:0]              coeff_i,
  input  logic                            sat_i,
  output logic signed [63:0]              f_o,
  output logic signed [PHASE_FRAC_BITS+9:0] x_o,
  output logic                            sat_o
);

  localparam int XW = PHASE_FRAC_BITS + 10;
  localparam int PW = 64 + XW;
  localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (PHASE_FRAC_BITS - 1);
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  logic signed [XW+32:0] plo_q;
  logic signed [XW+31:0] phi_q;
  logic                  neg_q;
  logic signed [XW-1:0]  x1_q, x2_q, x3_q;
  logic                  sat1_q, sat2_q, sat3_q;
  logic signed [PW:0]    rsum_d, rsum_q;
  logic signed [PW:0]    prod_hi, prod_lo;
  logic signed [PW:0]    sh;
  logic [PW-63:0]        sh_top;
  logic                  fit;
  logic signed [63:0]    msat;
  logic signed [64:0]    sum65;
  logic                  ov;
  logic signed [63:0]    f_d, f_q;

  // stage 1: split f into a signed high and unsigned low half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q  <= $signed({1'b0, f_i[31:0]}) * x_i;
      phi_q  <= $signed(f_i[63:32]) * x_i;
      neg_q  <= f_i[63] ^ x_i[XW-1];
      x1_q   <= x_i;
      sat1_q <= sat_i;
    end
  end

  // stage 2: full product plus round-half-away bias
  always_comb begin
    prod_hi = {phi_q[XW+31], phi_q, 32'd0};
    prod_lo = {{32{plo_q[XW+32]}}, plo_q};
    rsum_d  = prod_hi + prod_lo + RND - (PW+1)'(neg_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsum_q <= rsum_d;
      x2_q   <= x1_q;
      sat2_q <= sat1_q;
    end
  end

  // stage 3: shift, clamp to 64 bits, add coefficient with clamp
  always_comb begin
    sh     = rsum_q >>> PHASE_FRAC_BITS;
    sh_top = sh[PW:63];
    fit    = (&sh_top) | (~|sh_top);
    msat   = fit ? sh[63:0] : (rsum_q[PW] ? S64_MIN : S64_MAX);
    sum65  = {msat[63], msat} + {coeff_i[63], coeff_i};
    ov     = sum65[64] ^ sum65[63];
    f_d    = ov ? (sum65[64] ? S64_MIN : S64_MAX) : sum65[63:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q    <= f_d;
      x3_q   <= x2_q;
      sat3_q <= sat2_q | ~fit | ov;
    end
  end

  assign f_o   = f_q;
  assign x_o   = x3_q;
  assign sat_o = sat3_q;

endmodule

// File: design/rpc_poly.sv
// Degree-5 Horner evaluation as a chain of pipelined steps.
// Depends on rpc_pkg and rpc_step.
module rpc_poly #(
  parameter int PHASE_FRAC_BITS = rpc_pkg::PHASE_FRAC_BITS
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [PHASE_FRAC_BITS+9:0] x_i,
  input  rpc_pkg::coeff_set_t               coeff_i,
  output logic signed [63:0]                f_o,
  output logic signed [PHASE_FRAC_BITS+9:0] x_o,
  output logic                              sat_o
);

  logic signed [63:0]                f_c   [rpc_pkg::POLY_STEPS+1];
  logic signed [PHASE_FRAC_BITS+9:0] x_c   [rpc_pkg::POLY_STEPS+1];
  logic                              sat_c [rpc_pkg::POLY_STEPS+1];

  // seed with the top coefficient
  assign f_c[0]   = $signed(coeff_i[rpc_pkg::NUM_COEFF-1]);
  assign x_c[0]   = x_i;
  assign sat_c[0] = 1'b0;

  for (genvar k = 0; k < rpc_pkg::POLY_STEPS; k++) begin : g_step
    rpc_step #(
      .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_step (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .f_i    (f_c[k]),
      .x_i    (x_c[k]),
      .coeff_i($signed(coeff_i[rpc_pkg::NUM_COEFF-2-k])),
      .sat_i  (sat_c[k]),
      .f_o    (f_c[k+1]),
      .x_o    (x_c[k+1]),
      .sat_o  (sat_c[k+1])
    );
  end

  assign f_o   = f_c[rpc_pkg::POLY_STEPS];
  assign x_o   = x_c[rpc_pkg::POLY_STEPS];
  assign sat_o = sat_c[rpc_pkg::POLY_STEPS];

endmodule

// File: design/rpc_wrap.sv
// Wide wrap to [-180,180) degrees in four stages: 12-bit chunk folding
// mod 45, reciprocal reduce, sign fix, range fold. Depends on rpc_pkg.
module rpc_wrap #(
  parameter int PHASE_FRAC_BITS = rpc_pkg::PHASE_FRAC_BITS,
  parameter int IN_W            = 66
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [IN_W-1:0]            v_i,
  output logic signed [PHASE_FRAC_BITS+8:0] phase_o
);

  localparam int LO_W    = PHASE_FRAC_BITS + 3;
  localparam int HW      = IN_W - LO_W;
  localparam int NCH     = (HW + rpc_pkg::CHUNK_W - 1) / rpc_pkg::CHUNK_W;
  localparam int PAD_W   = NCH * rpc_pkg::CHUNK_W;
  localparam int SW      = rpc_pkg::CHUNK_SUM_W;
  localparam int QW      = 2 * SW - rpc_pkg::MOD_SHIFT;
  localparam int NEG_ADJ = rpc_pkg::MOD_BASE - rpc_pkg::pow2_mod(HW);
  localparam int MW      = PHASE_FRAC_BITS + 10;
  localparam logic signed [MW-1:0] HALF = MW'(180) <<< PHASE_FRAC_BITS;
  localparam logic signed [MW-1:0] FULL = MW'(360) <<< PHASE_FRAC_BITS;

  logic [PAD_W-1:0] hi_pad;
  logic [SW-1:0]    sum_d, sum1_q, sum2_q;
  logic             neg1_q, neg2_q;
  logic [LO_W-1:0]  lo1_q, lo2_q, lo3_q;
  logic [2*SW-1:0]  qprod;
  logic [QW-1:0]    q2_q;
  logic [SW-1:0]    qm, r_full;
  logic [6:0]       r7;
  logic [5:0]       r3_q;
  logic signed [MW-1:0] m, m_w;
  logic signed [MW-2:0] phase_q;

  // stage 1: fold the part above the 8-degree grain in 12-bit chunks
  always_comb begin
    hi_pad = PAD_W'(v_i[IN_W-1:LO_W]);
    sum_d  = '0;
    for (int k = 0; k < NCH; k++) begin
      sum_d = sum_d + SW'(hi_pad[k*rpc_pkg::CHUNK_W +: rpc_pkg::CHUNK_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum1_q <= sum_d;
      neg1_q <= v_i[IN_W-1];
      lo1_q  <= v_i[LO_W-1:0];
    end
  end

  // stage 2: quotient by 45 through the reciprocal
  assign qprod = (2*SW)'(sum1_q) * (2*SW)'(rpc_pkg::MOD_RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q2_q   <= qprod[2*SW-1:rpc_pkg::MOD_SHIFT];
      sum2_q <= sum1_q;
      neg2_q <= neg1_q;
      lo2_q  <= lo1_q;
    end
  end

  // stage 3: remainder, then take back the two's complement weight
  always_comb begin
    qm     = SW'(q2_q) * SW'(rpc_pkg::MOD_BASE);
    r_full = sum2_q - qm;
    r7     = 7'(r_full[5:0]) + (neg2_q ? 7'(NEG_ADJ) : 7'd0);
    if (r7 >= 7'(rpc_pkg::MOD_BASE)) begin
      r7 = r7 - 7'(rpc_pkg::MOD_BASE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r3_q  <= r7[5:0];
      lo3_q <= lo2_q;
    end
  end

  // stage 4: [0,360) to [-180,180)
  always_comb begin
    m   = $signed({1'b0, r3_q, lo3_q});
    m_w = (m >= HALF) ? (m - FULL) : m;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= m_w[MW-2:0];
    end
  end

  assign phase_o = phase_q;

endmodule

// File: design/rf_phase_calibration_unit.sv
// Top level of the phase calibration unit: config registers, front end,
// two Horner lanes, offset and final wrap. Depends on rpc_pkg and submodules.
//
//   channel   direction  handshake                payload
//   in        sink       in_valid_i / in_stall_o  raw_phase_i
//   out       source     out_valid_o/out_stall_i  phase_deg_o, wobble_flag_o, saturated_o
//   cfg       sink       cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One word per cycle while the output is not stalled; the pipeline runs through the
// front end, five three-stage Horner steps, the scale and offset registers and the four-stage mod-360 unit.
// The whole pipeline holds while the output word is stalled; bubbles hold too.
// Reset clears the valid bits and loads the identity polynomial, zero offset.
// The config port is always ready.
module rf_phase_calibration_unit #(
  parameter int PHASE_FRAC_BITS = rpc_pkg::PHASE_FRAC_BITS,
  parameter int COEFF_FRAC_BITS = rpc_pkg::COEFF_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [15:0]                           raw_phase_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [PHASE_FRAC_BITS+8:0]     phase_deg_o,
  output logic                                  wobble_flag_o,
  output logic                                  saturated_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [rpc_pkg::DATA_W-1:0]            cfg_data_i
);

  localparam int XW      = PHASE_FRAC_BITS + 10;
  localparam int PW      = PHASE_FRAC_BITS + 9;
  localparam int LAT     = rpc_pkg::PIPE_LAT;
  localparam int SAT_LAT = rpc_pkg::WRAP_LAT + 2;
  localparam int POLY_K  = rpc_pkg::FRONT_LAT + rpc_pkg::POLY_LAT;  // scale stage
  localparam int SCL     = COEFF_FRAC_BITS - PHASE_FRAC_BITS;
  localparam int VW      = 66;
  localparam logic signed [XW-1:0] FULL    = XW'(360) <<< PHASE_FRAC_BITS;
  localparam logic signed [XW-1:0] HALF    = XW'(180) <<< PHASE_FRAC_BITS;
  localparam logic signed [XW-1:0] QUARTER = XW'(90) <<< PHASE_FRAC_BITS;
  localparam logic signed [VW-1:0] V_HALF  = VW'(180) <<< PHASE_FRAC_BITS;
  localparam logic signed [PW-1:0] OUT_HALF = PW'(180) <<< PHASE_FRAC_BITS;
  // identity polynomial: only the linear term is one
  localparam rpc_pkg::coeff_set_t COEFF_RESET =
    (rpc_pkg::NUM_COEFF * rpc_pkg::DATA_W)'(1) << (rpc_pkg::DATA_W + COEFF_FRAC_BITS);

  logic                                en;
  logic [LAT-1:0]                      vld_q;
  logic [LAT-1:0]                      wob_q;
  logic [SAT_LAT-1:0]                  sat_q;
  logic signed [rpc_pkg::GOLD_W-1:0]   gold_q;
  rpc_pkg::coeff_set_t                 coeff_q;
  logic [20:0]                         scaled;
  logic signed [XW-1:0]                x_d, x_q;
  logic signed [XW-1:0]                praw_d, praw_q, praw2_q;
  logic signed [XW-1:0]                u, u_w, t_d, t_q;
  logic signed [63:0]                  lf;
  logic                                lsat, ssat;
  logic signed [64:0]                  ls_d, ls_q;
  logic signed [VW-1:0]                v_d, v_q;

  // hold the whole pipeline while the output word waits
  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gold_q  <= '0;
      coeff_q <= COEFF_RESET;
    end else if (cfg_valid_i) begin
      case (rpc_pkg::cfg_reg_e'(cfg_index_i))
        rpc_pkg::REG_GOLD_OFFSET: gold_q     <= cfg_data_i[rpc_pkg::GOLD_W-1:0];
        rpc_pkg::REG_COEFF_0:     coeff_q[0] <= cfg_data_i;
        rpc_pkg::REG_COEFF_1:     coeff_q[1] <= cfg_data_i;
        rpc_pkg::REG_COEFF_2:     coeff_q[2] <= cfg_data_i;
        rpc_pkg::REG_COEFF_3:     coeff_q[3] <= cfg_data_i;
        rpc_pkg::REG_COEFF_4:     coeff_q[4] <= cfg_data_i;
        rpc_pkg::REG_COEFF_5:     coeff_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // front end: one turn is 32768 counts, so bit 15 drops out of the phase
  assign scaled = 21'(raw_phase_i[14:0]) * 21'(rpc_pkg::RAW_SCALE);

  if (PHASE_FRAC_BITS >= 12) begin : g_scale_up
    assign x_d = XW'(scaled) <<< (PHASE_FRAC_BITS - 12);
  end else begin : g_scale_dn
    assign x_d = XW'((scaled + (21'(1) << (11 - PHASE_FRAC_BITS))) >> (12 - PHASE_FRAC_BITS));
  end

  assign praw_d = (x_q >= HALF) ? (x_q - FULL) : x_q;

  // add 180 when wobbled, refold to [-90,270)
  always_comb begin
    u = praw_q + (wob_q[1] ? HALF : '0) - QUARTER;
    if (u >= HALF) begin
      u_w = u - FULL;
    end else if (u < -HALF) begin
      u_w = u + FULL;
    end else begin
      u_w = u;
    end
    t_d = u_w + QUARTER;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wob_q   <= {wob_q[LAT-2:0], raw_phase_i[1]};
      x_q     <= x_d;
      praw_q  <= praw_d;
      praw2_q <= praw_q;
      t_q     <= t_d;
    end
  end

  rpc_poly #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_poly_l (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (t_q),
    .coeff_i(coeff_q),
    .f_o    (lf),
    .x_o    (),
    .sat_o  (lsat)
  );

  // second lane only feeds the saturation flag: its value cancels mod 360
  rpc_poly #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_poly_s (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (praw2_q),
    .coeff_i(coeff_q),
    .f_o    (),
    .x_o    (),
    .sat_o  (ssat)
  );

  // round the polynomial down to phase format
  if (SCL == 0) begin : g_noscale
    assign ls_d = {lf[63], lf};
  end else begin : g_scale
    assign ls_d = $signed({lf[63], lf} + (65'(1) <<< (SCL - 1)) - 65'(lf[63])) >>> SCL;
  end

  // result = L - wobble half turn - gold, wrapped once
  assign v_d = {ls_q[64], ls_q} - (wob_q[POLY_K] ? V_HALF : '0) - VW'(gold_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      ls_q  <= ls_d;
      v_q   <= v_d;
      sat_q <= {sat_q[SAT_LAT-2:0], lsat | ssat};
    end
  end

  rpc_wrap #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .IN_W           (VW)
  ) u_wrap (
    .clk_i  (clk_i),
    .en_i   (en),
    .v_i    (v_q),
    .phase_o(phase_deg_o)
  );

  assign out_valid_o   = vld_q[LAT-1];
  assign wobble_flag_o = wob_q[LAT-1];
  assign saturated_o   = sat_q[SAT_LAT-1];

`include "rf_phase_calibration_unit_macros.svh"

  `RPC_ASSERT_IMPL(a_phase_range, out_valid_o, (phase_deg_o >= -OUT_HALF) && (phase_deg_o < OUT_HALF), "phase out of range")
  `RPC_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, vld_q[0], "accepted word lost")
  `RPC_ASSERT_IMPL(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "stall without back-pressure")

endmodule
